// ===== src/dqvs_pkg.sv =====
// Shared types and constants for the double-ended queue with value search.
// No dependencies; used by every module in src.
package dqvs_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 7;
    localparam int CHUNK     = 8;
    localparam int TDATA_W   = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REMOVE     = 3'd4,
        ACT_COUNT      = 3'd5,
        ACT_READ       = 3'd6
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    // Entry update broadcast to every cell together
    typedef enum logic [1:0] {
        EOP_HOLD = 2'd0,
        EOP_SHR  = 2'd1,
        EOP_SHL  = 2'd2,
        EOP_LOAD = 2'd3
    } ent_op_t;

    typedef struct packed {
        ent_op_t ent_op;
        logic    cmp;
        logic    scan;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

// ===== src/dqvs_cell.sv =====
// One storage cell of the queue chain: an entry and a match flag.
// Depends on dqvs_pkg.
module dqvs_cell #(
    parameter int IDX = 0,
    parameter int AW  = 6,
    parameter int CW  = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dqvs_pkg::cell_ctl_t           ctl,
    input  logic [AW-1:0]                 sel_idx,
    input  logic [CW-1:0]                 count,
    input  logic [dqvs_pkg::DATA_W-1:0]   load_value,
    input  logic [dqvs_pkg::DATA_W-1:0]   left_entry,
    input  logic [dqvs_pkg::DATA_W-1:0]   right_entry,
    input  logic                          match_in,
    output logic [dqvs_pkg::DATA_W-1:0]   entry,
    output logic                          match
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [dqvs_pkg::DATA_W-1:0] entry_reg;
    logic [dqvs_pkg::DATA_W-1:0] entry_next;
    logic                        match_reg;
    logic                        match_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.ent_op)
            dqvs_pkg::EOP_SHR:
            begin
                entry_next = left_entry;
            end
            dqvs_pkg::EOP_SHL:
            begin
                if (MY_IDX >= sel_idx)
                begin
                    entry_next = right_entry;
                end
            end
            dqvs_pkg::EOP_LOAD:
            begin
                if (MY_IDX == sel_idx)
                begin
                    entry_next = load_value;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Compare against the key, or pass the flag one chunk towards the front
    always_comb
    begin
        if (ctl.cmp)
        begin
            match_next = (MY_POS < count) && (entry_reg == load_value);
        end
        else if (ctl.scan)
        begin
            match_next = match_in;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ===== src/dqvs_scan.sv =====
// Match scanner: counts and locates match flags, one chunk of eight per cycle.
// Depends on dqvs_pkg.
module dqvs_scan #(
    parameter int DEPTH = dqvs_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                step,
    input  logic [dqvs_pkg::CHUNK-1:0]          bits,
    output logic                                hit,
    output logic [$clog2(DEPTH)-1:0]            hit_idx,
    output logic [$clog2(DEPTH+1)-1:0]          total,
    output logic                                last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int NCH = (DEPTH + dqvs_pkg::CHUNK - 1) / dqvs_pkg::CHUNK;
    localparam int CKW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int EW  = $clog2(dqvs_pkg::CHUNK);
    localparam int IW  = CKW + EW;

    logic [CKW-1:0] chunk_reg;
    logic [CKW-1:0] chunk_next;
    logic [CW-1:0]  acc_reg;
    logic [CW-1:0]  acc_next;
    logic [EW-1:0]  enc;
    logic [EW:0]    pop;
    logic [IW-1:0]  raw_idx;

    always_comb
    begin
        enc = '0;
        pop = '0;
        for (int i = dqvs_pkg::CHUNK - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                enc = EW'(i);
            end
        end
        for (int i = 0; i < dqvs_pkg::CHUNK; i++)
        begin
            pop = pop + (EW + 1)'(bits[i]);
        end
    end

    assign hit     = |bits;
    assign raw_idx = {chunk_reg, enc};
    assign hit_idx = AW'(raw_idx);
    assign total   = acc_reg + CW'(pop);
    assign last    = (chunk_reg == CKW'(NCH - 1));

    always_comb
    begin
        chunk_next = chunk_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            chunk_next = '0;
            acc_next   = '0;
        end
        else if (step)
        begin
            chunk_next = chunk_reg + 1'b1;
            acc_next   = total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            chunk_reg <= chunk_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ===== src/deque_with_value_search_core.sv =====
// Top level of the double-ended queue with value search: cell chain, scanner, control.
// Depends on dqvs_pkg, dqvs_cell and dqvs_scan.
//
//   Channel  | Dir | Handshake                    | Payload (tdata, low bit first)
//   s_axis   | in  | s_axis_tvalid/s_axis_tready  | action[2:0] value[34:3] position[40:35]
//   m_axis   | out | m_axis_tvalid/m_axis_tready  | result_value[31:0] status[33:32]
//                                                  | occupancy[40:34]
//
// Insert, remove front/back, read and the unused code need no scan: the chain of
// cells shifts or loads in parallel and the result lands in the output register.
// Remove-value and count also scan up to ceil(DEPTH/8) chunks: all cells compare at
// once, then the match flags walk down the chain eight cells per cycle into the
// scanner; remove stops at the chunk with the first match.
// rst_n empties the list; entries are never cleared and are read only below the count.
// The output register holds a result while m_axis_tready is low; a new transaction is
// taken in the same cycle the previous result leaves.
module deque_with_value_search_core #(
    parameter int DEPTH = dqvs_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // action[2:0], value[34:3], position[40:35], zero pad[47:41]
    input  logic [dqvs_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result_value[31:0], status[33:32], occupancy[40:34], zero pad[47:41]
    output logic [dqvs_pkg::TDATA_W-1:0]   m_axis_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = dqvs_pkg::DATA_W;
    localparam int CH    = dqvs_pkg::CHUNK;
    localparam int RD_N  = (DEPTH < (1 << dqvs_pkg::POS_W)) ? DEPTH : (1 << dqvs_pkg::POS_W);
    localparam int CMPW  = (CW > dqvs_pkg::POS_W) ? CW : dqvs_pkg::POS_W;
    localparam int OUT_W = DW + dqvs_pkg::STAT_W + dqvs_pkg::OCC_W;

    // Unpack the command
    logic [dqvs_pkg::ACT_W-1:0] in_action;
    logic [DW-1:0]              in_value;
    logic [dqvs_pkg::POS_W-1:0] in_position;

    assign in_action   = s_axis_tdata[dqvs_pkg::ACT_W-1:0];
    assign in_value    = s_axis_tdata[dqvs_pkg::ACT_W +: DW];
    assign in_position = s_axis_tdata[dqvs_pkg::ACT_W + DW +: dqvs_pkg::POS_W];

    dqvs_pkg::state_t  state_reg;
    dqvs_pkg::state_t  state_next;
    dqvs_pkg::action_t act_reg;
    dqvs_pkg::action_t act_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [DW-1:0]        res_reg;
    logic [DW-1:0]        res_next;
    dqvs_pkg::status_t    stat_reg;
    dqvs_pkg::status_t    stat_next;
    logic [dqvs_pkg::OCC_W-1:0] occ_reg;
    logic [dqvs_pkg::OCC_W-1:0] occ_next;

    dqvs_pkg::cell_ctl_t ctl;
    logic [AW-1:0]       sel_idx;
    logic                accept;
    logic                scan_start;
    logic                scan_step;

    logic [DW-1:0]  ent [DEPTH];
    logic [DEPTH-1:0] match_vec;
    logic [CH-1:0]  scan_bits;
    logic           scan_hit;
    logic [AW-1:0]  scan_idx;
    logic [CW-1:0]  scan_total;
    logic           scan_last;

    logic [DW-1:0]  rd_val;
    logic           rd_ok;
    logic           is_full;
    logic           is_empty;

    assign s_axis_tready = (state_reg == dqvs_pkg::S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_full       = (count_reg == CW'(DEPTH));
    assign is_empty      = (count_reg == '0);

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] left_e;
        logic [DW-1:0] right_e;
        logic          m_in;

        if (i == 0)
        begin : g_first
            assign left_e = in_value;
        end
        else
        begin : g_mid
            assign left_e = ent[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = ent[i+1];
        end

        if (i + CH < DEPTH)
        begin : g_mfeed
            assign m_in = match_vec[i+CH];
        end
        else
        begin : g_mend
            assign m_in = 1'b0;
        end

        dqvs_cell #(
            .IDX (i),
            .AW  (AW),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .sel_idx     (sel_idx),
            .count       (count_reg),
            .load_value  (in_value),
            .left_entry  (left_e),
            .right_entry (right_e),
            .match_in    (m_in),
            .entry       (ent[i]),
            .match       (match_vec[i])
        );
    end

    // Front chunk of match flags feeds the scanner; pad past the last cell
    always_comb
    begin
        scan_bits = '0;
        for (int i = 0; i < CH; i++)
        begin
            if (i < DEPTH)
            begin
                scan_bits[i] = match_vec[i];
            end
        end
    end

    dqvs_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .step    (scan_step),
        .bits    (scan_bits),
        .hit     (scan_hit),
        .hit_idx (scan_idx),
        .total   (scan_total),
        .last    (scan_last)
    );

    // Read by position: only the first RD_N cells are reachable by the field
    always_comb
    begin
        rd_val = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (in_position == dqvs_pkg::POS_W'(i))
            begin
                rd_val = ent[i];
            end
        end
    end

    assign rd_ok = CMPW'(in_position) < CMPW'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        stat_next    = stat_reg;
        ctl          = '{ent_op: dqvs_pkg::EOP_HOLD, cmp: 1'b0, scan: 1'b0};
        sel_idx      = '0;
        scan_start   = 1'b0;
        scan_step    = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            dqvs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    m_valid_next = 1'b1;
                    res_next     = '0;
                    stat_next    = dqvs_pkg::ST_OK;
                    case (in_action)
                        dqvs_pkg::ACT_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                stat_next = dqvs_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.ent_op = dqvs_pkg::EOP_SHR;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dqvs_pkg::ACT_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                stat_next = dqvs_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.ent_op = dqvs_pkg::EOP_LOAD;
                                sel_idx    = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dqvs_pkg::ACT_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dqvs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.ent_op = dqvs_pkg::EOP_SHL;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        dqvs_pkg::ACT_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dqvs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        dqvs_pkg::ACT_REMOVE,
                        dqvs_pkg::ACT_COUNT:
                        begin
                            // Compare all cells now, result comes from the scan
                            m_valid_next = m_valid_reg && !m_axis_tready;
                            ctl.cmp      = 1'b1;
                            scan_start   = 1'b1;
                            act_next     = dqvs_pkg::action_t'(in_action);
                            state_next   = dqvs_pkg::S_SCAN;
                        end
                        dqvs_pkg::ACT_READ:
                        begin
                            if (rd_ok)
                            begin
                                res_next = rd_val;
                            end
                            else
                            begin
                                res_next  = '1;
                                stat_next = dqvs_pkg::ST_MISS;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            dqvs_pkg::S_SCAN:
            begin
                ctl.scan  = 1'b1;
                scan_step = 1'b1;
                if ((act_reg == dqvs_pkg::ACT_REMOVE) && scan_hit)
                begin
                    // Close the gap at the first match
                    ctl.ent_op   = dqvs_pkg::EOP_SHL;
                    sel_idx      = scan_idx;
                    count_next   = count_reg - 1'b1;
                    m_valid_next = 1'b1;
                    res_next     = '0;
                    stat_next    = dqvs_pkg::ST_OK;
                    state_next   = dqvs_pkg::S_IDLE;
                end
                else if (scan_last)
                begin
                    m_valid_next = 1'b1;
                    state_next   = dqvs_pkg::S_IDLE;
                    if (act_reg == dqvs_pkg::ACT_REMOVE)
                    begin
                        res_next  = '0;
                        stat_next = dqvs_pkg::ST_MISS;
                    end
                    else
                    begin
                        res_next  = DW'(scan_total);
                        stat_next = dqvs_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = dqvs_pkg::S_IDLE;
            end
        endcase
    end

    assign occ_next = dqvs_pkg::OCC_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dqvs_pkg::S_IDLE;
            act_reg     <= dqvs_pkg::ACT_COUNT;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            act_reg     <= act_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: load only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (m_valid_next && !(m_valid_reg && !m_axis_tready))
        begin
            res_reg  <= res_next;
            stat_reg <= stat_next;
            occ_reg  <= occ_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(dqvs_pkg::TDATA_W - OUT_W){1'b0}}, occ_reg, stat_reg, res_reg};

endmodule

// ===== bench/deque_with_value_search_core_chk.sv =====
`timescale 1ns / 1ps
// Checker for the double-ended queue with value search: watches both stream channels,
// predicts each reply from a shadow list and compares. Depends on dqvs_pkg.
module deque_with_value_search_core_chk #(
    parameter int DEPTH = dqvs_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [dqvs_pkg::TDATA_W-1:0] s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [dqvs_pkg::TDATA_W-1:0] m_axis_tdata,
    output int                           mismatches,
    output int                           outstanding
);
    import dqvs_pkg::*;

    typedef struct packed {
        logic [OCC_W-1:0]         occupancy;
        status_t                  status;
        logic signed [DATA_W-1:0] value;
    } reply_t;

    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int                       shadow_count;
    reply_t                   replies_due [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // close the gap at one position of the shadow list
    function automatic void drop_entry(int at);
        for (int i = at; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        shadow_count--;
    endfunction

    function automatic reply_t apply_command(logic [ACT_W-1:0] act,
                                             logic signed [DATA_W-1:0] val,
                                             logic [POS_W-1:0] pos);
        reply_t r;
        int     hit;
        r.value  = '0;
        r.status = ST_OK;
        hit      = -1;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        for (int i = shadow_count; i > 0; i--)
                            shadow_entries[i] = shadow_entries[i - 1];
                        shadow_entries[0] = val;
                    end
                    else
                        shadow_entries[shadow_count] = val;
                    shadow_count++;
                end
            end
            ACT_POP_FRONT:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                    drop_entry(0);
            end
            ACT_POP_BACK:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_count--;
            end
            ACT_REMOVE:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_entries[i] == val)
                        hit = i;
                if (hit < 0)
                    r.status = ST_MISS;
                else
                    drop_entry(hit);
            end
            ACT_COUNT:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_entries[i] == val)
                        r.value++;
            end
            ACT_READ:
            begin
                if (pos < shadow_count)
                    r.value = shadow_entries[pos];
                else
                begin
                    r.value  = -1;
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        $display("chk: %s at %0t ns: expected %0h, got %0h", what, $time, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            shadow_count = 0;
            replies_due.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(apply_command(s_axis_tdata[ACT_W-1:0],
                                                    s_axis_tdata[ACT_W+DATA_W-1:ACT_W],
                                                    s_axis_tdata[ACT_W+DATA_W+POS_W-1:
                                                                 ACT_W+DATA_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value     = m_axis_tdata[DATA_W-1:0];
                got.status    = status_t'(m_axis_tdata[DATA_W+STAT_W-1:DATA_W]);
                got.occupancy = m_axis_tdata[DATA_W+STAT_W+OCC_W-1:DATA_W+STAT_W];
                if (replies_due.size() == 0)
                    report_mismatch("reply with none pending", '0, got.value);
                else
                begin
                    want = replies_due.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("result_value", want.value, got.value);
                    if (got.status !== want.status)
                        report_mismatch("status", DATA_W'(want.status),
                                        DATA_W'(got.status));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", DATA_W'(want.occupancy),
                                        DATA_W'(got.occupancy));
                end
            end
        end
        outstanding = replies_due.size();
    end

endmodule

// ===== bench/deque_with_value_search_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the deque-with-value-search bench: clock, reset, command stimulus, reply sink.
// Depends on dqvs_pkg, deque_with_value_search_core and deque_with_value_search_core_chk.
module deque_with_value_search_core_tb;
    import dqvs_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // the one action code the block treats as a no-op
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    // shapes of the random rounds
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    // idling styles for either side
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_FULL   = 1;
    localparam int IDLE_SPARSE = 2;

    localparam int TARGET_ITEMS = 650;
    localparam int SQUEEZE_AT   = 250;   // reply count at which the sink holds off
    localparam int SQUEEZE_LEN  = 300;   // cycles of that hold-off

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int sent_count;
    int taken_count;
    int tx_idle_mode;
    int rx_idle_mode;

    // action menu indexed by the random draws below
    logic [ACT_W-1:0] act_menu [8];

    deque_with_value_search_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    deque_with_value_search_core_chk #(
        .DEPTH (DEPTH)
    ) u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // 2 ns period
    always #1 clk = ~clk;

    // Drive every input to a known level at time zero.
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        sent_count    = 0;
        taken_count   = 0;
        tx_idle_mode  = IDLE_NONE;
        rx_idle_mode  = IDLE_NONE;
        act_menu      = '{ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_POP_FRONT, ACT_POP_BACK,
                          ACT_REMOVE, ACT_COUNT, ACT_READ, ACT_UNUSED};
    end

    // Number of idle cycles before the next transaction on one side.
    function automatic int draw_gap(int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 14);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    // Values cluster on a small pool so that remove and count find matches often;
    // the rest are extremes and full 32-bit noise.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $signed($urandom_range(0, 7)) - 3;
        if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    // Fill rounds lean on inserts so the list reaches full; drain rounds lean on
    // removals so the empty cases come round again.
    function automatic logic [ACT_W-1:0] pick_action(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (r < 75) ? act_menu[3'($urandom_range(0, 1))]
                                : act_menu[3'($urandom_range(2, 7))];
            MODE_DRAIN:
            begin
                if (r < 65)
                    return act_menu[3'($urandom_range(2, 4))];
                if (r < 80)
                    return act_menu[3'($urandom_range(0, 1))];
                return act_menu[3'($urandom_range(5, 7))];
            end
            default:
                return act_menu[3'($urandom_range(0, 7))];
        endcase
    endfunction

    // Offer one command after a random gap and hold it until the block takes it.
    // Entered and left at a falling edge.
    task automatic send_command(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                                logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap(tx_idle_mode);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W - ACT_W - DATA_W - POS_W){1'b0}}, pos, val, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        sent_count++;
    endtask

    // Reply sink: random back-pressure, styles changing every 40 replies, and one long
    // hold-off so that the output register fills and the block stalls its input.
    initial
    begin
        int  gap;
        bit  squeezed;
        squeezed = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken_count % 40 == 0)
                rx_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            if (taken_count == SQUEEZE_AT && !squeezed)
            begin
                squeezed = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_LEN) @(negedge clk);
            end
            gap = draw_gap(rx_idle_mode);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
            taken_count++;
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // Main stimulus and verdict.
    initial
    begin
        int mode;
        int round_len;
        wait (clk === 1'b0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-list cases first, then extremes, duplicates and misses.
        tx_idle_mode = IDLE_SPARSE;
        send_command(ACT_POP_FRONT, 32'sd7, 6'd0);              // remove from empty
        send_command(ACT_POP_BACK, -1, 6'd63);                  // remove from empty
        send_command(ACT_REMOVE, 32'sd5, 6'd0);                 // no match on empty list
        send_command(ACT_COUNT, 0, 6'd0);                       // count of zero is ok
        send_command(ACT_READ, 0, 6'd0);                        // read past the end
        send_command(ACT_UNUSED, 32'sh1234_5678, 6'd21);        // no-op code
        send_command(ACT_PUSH_BACK, 32'sh7FFF_FFFF, 6'd0);
        send_command(ACT_PUSH_FRONT, 32'sh8000_0000, 6'd63);
        send_command(ACT_PUSH_BACK, -1, 6'd42);
        send_command(ACT_PUSH_FRONT, 0, 6'd0);
        send_command(ACT_PUSH_BACK, -1, 6'd0);                  // list: 0 MIN MAX -1 -1
        send_command(ACT_READ, 0, 6'd0);
        send_command(ACT_READ, 0, 6'd4);
        send_command(ACT_READ, 0, 6'd63);                       // position out of range
        send_command(ACT_COUNT, -1, 6'd0);                      // two matches
        send_command(ACT_COUNT, 32'sd12345, 6'd0);              // no match, status ok
        send_command(ACT_REMOVE, -1, 6'd0);                     // first of the duplicates
        send_command(ACT_REMOVE, 32'sd777, 6'd0);               // value not found
        send_command(ACT_READ, 0, 6'd4);                        // now just past the end
        send_command(ACT_POP_FRONT, 0, 6'd0);
        send_command(ACT_POP_BACK, 0, 6'd0);
        send_command(ACT_PUSH_BACK, 32'sh5555_5555, 6'd21);
        send_command(ACT_PUSH_FRONT, 32'shAAAA_AAAA, 6'd42);
        send_command(ACT_UNUSED, -1, 6'd63);

        // Random rounds; the first one fills the list past full so the dropped-insert
        // case is reached early, the rest wander between full and empty.
        mode      = MODE_FILL;
        round_len = 130;
        while (sent_count < TARGET_ITEMS)
        begin
            tx_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            repeat (round_len)
                send_command(pick_action(mode), pick_value(),
                             POS_W'($urandom_range(0, 63)));
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            round_len = $urandom_range(30, 90);
        end
        s_axis_tvalid <= 1'b0;

        // Drain the replies, then allow for a late stray one from a scan.
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
